[hdl/hrsv_pkg.sv]
package hrsv_pkg;

  // Width of the internal character and record counters
  localparam int unsigned COUNTER_WIDTH = 32;
  localparam int unsigned TOTAL_WIDTH   = 32;
  localparam int unsigned REM_WIDTH     = 10;

  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_S_UPPER = 8'h53;
  localparam logic [7:0] CH_S_LOWER = 8'h73;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic [7:0]           SUM_SREC   = 8'hFF;
  localparam logic [7:0]           SUM_IHEX   = 8'h00;
  localparam logic [REM_WIDTH-1:0] IHEX_EXTRA = REM_WIDTH'(8);

  typedef logic [COUNTER_WIDTH-1:0] cnt_t;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_STYPE  = 3'd1,
    PH_CNT_HI = 3'd2,
    PH_CNT_LO = 3'd3,
    PH_BODY   = 3'd4,
    PH_EOL    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_SREC = 2'd1,
    FMT_IHEX = 2'd2
  } fmt_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FORMAT = 2'd1,
    ST_LENGTH = 2'd2,
    ST_VALUES = 2'd3
  } status_e;

  typedef struct packed {
    phase_e                phase;
    fmt_e                  fmt;
    logic [REM_WIDTH-1:0]  chars_rem;
    logic [7:0]            sum;
    logic [3:0]            high_nibble;
    logic                  parity;
    logic                  bad_digit;
    logic                  failed;
    cnt_t                  char_cnt;
    cnt_t                  rec_cnt;
  } state_t;

  typedef struct packed {
    status_e                status;
    logic [TOTAL_WIDTH-1:0] char_total;
    logic [TOTAL_WIDTH-1:0] record_total;
    fmt_e                   fmt;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_START,
    fmt:         FMT_NONE,
    chars_rem:   '0,
    sum:         '0,
    high_nibble: '0,
    parity:      1'b0,
    bad_digit:   1'b0,
    failed:      1'b0,
    char_cnt:    '0,
    rec_cnt:     '0
  };

  // Returns {ok, value}; a non-hex character reads as zero
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == '1) ? v : v + cnt_t'(1);
  endfunction

  function automatic logic [TOTAL_WIDTH-1:0] clip_total(cnt_t v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? '1 : w[TOTAL_WIDTH-1:0];
  endfunction

endpackage

[hdl/hrsv_stream_if.sv]
interface hrsv_in_if
  import hrsv_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_file;

  modport source (output valid, output ch, output end_of_file, input ready);
  modport sink   (input valid, input ch, input end_of_file, output ready);
endinterface

interface hrsv_out_if
  import hrsv_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [TOTAL_WIDTH-1:0] char_total;
  logic [TOTAL_WIDTH-1:0] record_total;
  logic [1:0]             record_format;

  modport source (output valid, output status, output char_total, output record_total,
                  output record_format, input ready);
  modport sink   (input valid, input status, input char_total, input record_total,
                  input record_format, output ready);
endinterface

[hdl/hrsv_step.sv]
module hrsv_step
  import hrsv_pkg::*;
(
  input  state_t     state_i,
  input  logic [7:0] ch_i,
  input  logic       eof_i,
  output state_t     state_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic                 is_srec;
  logic                 is_ihex;
  fmt_e                 want;
  logic [4:0]           dig;
  logic [7:0]           byte_val;
  logic [REM_WIDTH-1:0] rem_dec;
  logic                 is_nl;
  logic                 fail;
  status_e              fail_status;
  logic                 count_char;

  assign is_srec  = (ch_i == CH_S_UPPER) || (ch_i == CH_S_LOWER);
  assign is_ihex  = (ch_i == CH_COLON);
  assign want     = is_srec ? FMT_SREC : FMT_IHEX;
  assign dig      = hex_digit(ch_i);
  assign byte_val = {state_i.high_nibble, dig[3:0]};
  assign rem_dec  = state_i.chars_rem - REM_WIDTH'(1);
  assign is_nl    = (ch_i == CH_NEWLINE);

  always_comb begin
    state_o     = state_i;
    fail        = 1'b0;
    fail_status = ST_OK;
    count_char  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_OK, char_total: '0, record_total: '0, fmt: state_i.fmt};

    if (eof_i) begin
      // close the file and rearm
      res_valid_o = !state_i.failed;
      if (state_i.phase != PH_START) begin
        res_o.status = ST_LENGTH;
      end else begin
        res_o.char_total   = clip_total(state_i.char_cnt);
        res_o.record_total = clip_total(state_i.rec_cnt);
      end
      state_o = STATE_RESET;
    end else if (!state_i.failed) begin
      count_char = 1'b1;
      unique case (state_i.phase)
        PH_START: begin
          if (!(is_srec || is_ihex)) begin
            fail        = 1'b1;
            fail_status = ST_FORMAT;
          end else if (state_i.fmt != FMT_NONE && state_i.fmt != want) begin
            fail        = 1'b1;
            fail_status = ST_FORMAT;
          end else begin
            state_o.fmt       = want;
            state_o.sum       = '0;
            state_o.bad_digit = 1'b0;
            state_o.parity    = 1'b0;
            state_o.phase     = is_srec ? PH_STYPE : PH_CNT_HI;
          end
        end
        PH_STYPE: begin
          if (is_nl) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else begin
            state_o.phase = PH_CNT_HI;
          end
        end
        PH_CNT_HI: begin
          if (is_nl) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else begin
            state_o.high_nibble = dig[3:0];
            state_o.bad_digit   = state_i.bad_digit | !dig[4];
            state_o.phase       = PH_CNT_LO;
          end
        end
        PH_CNT_LO: begin
          if (is_nl) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else if (state_i.fmt == FMT_SREC && byte_val == 8'h00) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else begin
            state_o.sum       = byte_val;
            state_o.bad_digit = state_i.bad_digit | !dig[4];
            state_o.chars_rem = (state_i.fmt == FMT_SREC) ?
                                {1'b0, byte_val, 1'b0} :
                                {1'b0, byte_val, 1'b0} + IHEX_EXTRA;
            state_o.parity    = 1'b0;
            state_o.phase     = PH_BODY;
          end
        end
        PH_BODY: begin
          if (is_nl) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else begin
            state_o.bad_digit = state_i.bad_digit | !dig[4];
            if (!state_i.parity) begin
              state_o.high_nibble = dig[3:0];
              state_o.parity      = 1'b1;
            end else begin
              state_o.sum    = state_i.sum + byte_val;
              state_o.parity = 1'b0;
            end
            state_o.chars_rem = rem_dec;
            if (rem_dec == '0) begin
              state_o.phase = PH_EOL;
            end
          end
        end
        PH_EOL: begin
          if (!is_nl) begin
            fail        = 1'b1;
            fail_status = ST_LENGTH;
          end else if (state_i.bad_digit) begin
            fail        = 1'b1;
            fail_status = ST_VALUES;
          end else if (state_i.sum != ((state_i.fmt == FMT_SREC) ? SUM_SREC : SUM_IHEX)) begin
            fail        = 1'b1;
            fail_status = ST_VALUES;
          end else begin
            state_o.rec_cnt = sat_inc(state_i.rec_cnt);
            state_o.phase   = PH_START;
          end
        end
        default: begin
          count_char    = 1'b0;
          state_o.phase = PH_START;
        end
      endcase

      if (fail) begin
        // report once, then drop everything up to end of file
        state_o             = state_i;
        state_o.failed      = 1'b1;
        res_valid_o         = 1'b1;
        res_o.status        = fail_status;
      end else if (count_char) begin
        state_o.char_cnt = sat_inc(state_i.char_cnt);
      end
    end
  end

endmodule

[hdl/hex_record_stream_validator.sv]
// Checks a text file of Motorola S-records or Intel Hex records, one character word per
// cycle, closed by an end-of-file word. The word is captured in an input register, then
// the state update writes at most one result into the output register, so a result is
// valid once its word has passed the input register and the output register. A word can
// be taken every cycle while results are taken; a held result that is not taken stops the
// state update and, once the input register is full as well, the input side; nothing else
// throttles the block. A result comes at the first error (status 1..3, totals zero) or at
// end of file of a clean file (status 0 with character and record totals). After an error
// the rest of the file is dropped without results; end of file always rearms the block.
module hex_record_stream_validator
  import hrsv_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  hrsv_in_if.sink       in_i,
  hrsv_out_if.source    out_o
);

  logic       in_vld_q;
  logic [7:0] in_ch_q;
  logic       in_eof_q;

  state_t     state_q;
  state_t     state_d;
  logic       res_vld;
  result_t    res;

  logic       out_vld_q;
  result_t    out_q;

  logic       consume;
  logic       take_in;

  // advance the held word only when the output slot is free or draining
  assign consume   = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || consume;
  assign take_in   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take_in) begin
      in_vld_q <= 1'b1;
    end else if (consume) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_ch_q  <= in_i.ch;
      in_eof_q <= in_i.end_of_file;
    end
  end

  hrsv_step u_step (
    .state_i     (state_q),
    .ch_i        (in_ch_q),
    .eof_i       (in_eof_q),
    .state_o     (state_d),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (consume) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (consume) begin
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && res_vld) begin
      out_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.status        = out_q.status;
  assign out_o.char_total    = out_q.char_total;
  assign out_o.record_total  = out_q.record_total;
  assign out_o.record_format = out_q.fmt;

endmodule

[hdl/hrsv_checker.sv]
module hrsv_checker
  import hrsv_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [1:0]             status_i,
  input logic [TOTAL_WIDTH-1:0] char_total_i,
  input logic [TOTAL_WIDTH-1:0] record_total_i,
  input logic [1:0]             record_format_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(char_total_i) && $stable(record_total_i) && $stable(record_format_i))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> char_total_i == '0 && record_total_i == '0)
    else $error("error result carries nonzero totals");

  a_rec_fmt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK && record_total_i != '0 |-> record_format_i != FMT_NONE)
    else $error("records counted without a format");

  a_chars_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_OK |-> char_total_i >= record_total_i)
    else $error("more records than characters");

endmodule

bind hex_record_stream_validator hrsv_checker u_hrsv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .char_total_i    (out_o.char_total),
  .record_total_i  (out_o.record_total),
  .record_format_i (out_o.record_format)
);
